// ===== hw/rtl/sha1md_pkg.sv =====
`timescale 1ns / 1ps

package sha1md_pkg;

  // One input transaction: a message byte and its framing flags.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       no_data;
  } byte_item_t;

  // One result transaction: the 160-bit digest in three fields.
  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_mid;
    logic [31:0] digest_low;
  } digest_item_t;

  // Initial chaining values.
  localparam logic [31:0] H0_INIT = 32'h6745_2301;
  localparam logic [31:0] H1_INIT = 32'hEFCD_AB89;
  localparam logic [31:0] H2_INIT = 32'h98BA_DCFE;
  localparam logic [31:0] H3_INIT = 32'h1032_5476;
  localparam logic [31:0] H4_INIT = 32'hC3D2_E1F0;

  // Round constants, one per group of twenty rounds.
  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Schedule memory geometry and round sequencing.
  localparam int unsigned BlockWords = 16;
  localparam int unsigned AddrW      = 4;
  localparam int unsigned PreCycles  = 3;
  localparam int unsigned Rounds     = 80;
  localparam logic [6:0]  LastCnt    = 7'(PreCycles + Rounds - 1);
  localparam logic [6:0]  FirstExp   = 7'(PreCycles + BlockWords);

endpackage

// ===== hw/rtl/sha1md_ram.sv =====
`timescale 1ns / 1ps

module sha1md_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== hw/rtl/sha1_message_digest_top.sv =====
`timescale 1ns / 1ps
// Byte transactions are taken only in the idle state; every 64th byte starts a block compression
// (prefetch, 80 rounds at one per cycle, a chaining add). No bytes are taken during a
// compression, as the one schedule memory is shared by loading and rounds.
// A final transaction adds padding (end mark, zero fill, bit length), one or two
// compressions and the digest output register before the digest transaction.
// Synchronous reset restores the initial chaining values and clears the bit and byte counts.
module sha1_message_digest_top
  import sha1md_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_ready,
  input  byte_item_t   byte_data,
  output logic         digest_valid,
  input  logic         digest_ready,
  output digest_item_t digest
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD_MARK,
    S_PAD_FILL,
    S_COMP,
    S_FIN,
    S_OUT
  } state_t;

  state_t state;

  logic [31:0] h0, h1, h2, h3, h4;
  logic [31:0] wa, wb, wc, wd, we;
  logic [31:0] wh0, wh1, wh2;
  logic [31:0] dl1, dl2;
  logic [63:0] bc;
  logic [5:0]  bp;
  logic [23:0] acc;
  logic [6:0]  cnt;
  logic [AddrW-1:0] wp;
  logic        finishing;
  logic        mark_done;
  logic        len_blk;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [31:0]       ram_wdata;
  logic [31:0]       rd_a;
  logic [31:0]       rd_b;
  logic [AddrW-1:0]  rd_addr_b;

  logic        accept;
  logic        take_byte;
  logic [6:0]  rnd;
  logic [31:0] w_new;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;
  logic [31:0] mark_word;

  assign byte_ready = (state == S_IDLE);
  assign accept     = byte_valid && byte_ready;
  assign take_byte  = accept && !byte_data.no_data;
  assign rnd        = cnt - 7'(PreCycles);
  assign rd_addr_b  = cnt[AddrW-1:0] + AddrW'(6);

  // Message schedule: the block words, rewritten in place during the rounds.
  sha1md_ram #(
    .WIDTH(32),
    .DEPTH(BlockWords)
  ) u_sched (
    .clk      (clk),
    .wr_en    (ram_we),
    .wr_addr  (ram_waddr),
    .wr_data  (ram_wdata),
    .rd_addr_a(cnt[AddrW-1:0]),
    .rd_data_a(rd_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_b(rd_b)
  );

  // Round datapath. Port A returns W[r-14], port B W[r-8]; W[r-16] arrives through a
  // two-stage delay of port A and W[r-3] from the history of recent schedule words.
  always_comb begin
    logic [31:0] x;
    x = wh2 ^ rd_b ^ rd_a ^ dl2;
    if (rnd < 7'd16) begin
      w_new = dl2;
    end else begin
      w_new = {x[30:0], x[31]};
    end
    if (rnd < 7'd20) begin
      f_val = (wb & wc) | (~wb & wd);
      k_val = K0;
    end else if (rnd < 7'd40) begin
      f_val = wb ^ wc ^ wd;
      k_val = K1;
    end else if (rnd < 7'd60) begin
      f_val = (wb & wc) | (wb & wd) | (wc & wd);
      k_val = K2;
    end else begin
      f_val = wb ^ wc ^ wd;
      k_val = K3;
    end
    t_val = {wa[26:0], wa[31:27]} + f_val + we + k_val + w_new;
  end

  // Word holding the end-of-message mark after the bytes already collected.
  always_comb begin
    case (bp[1:0])
      2'd0:    mark_word = {PAD_MARK, 24'h0};
      2'd1:    mark_word = {acc[7:0], PAD_MARK, 16'h0};
      2'd2:    mark_word = {acc[15:0], PAD_MARK, 8'h0};
      2'd3:    mark_word = {acc[23:0], PAD_MARK};
      default: mark_word = {PAD_MARK, 24'h0};
    endcase
  end

  // Schedule memory write selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bp[5:2];
    ram_wdata = {acc, byte_data.data_byte};
    case (state)
      S_IDLE: begin
        ram_we = take_byte && (bp[1:0] == 2'd3);
      end
      S_PAD_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = mark_word;
      end
      S_PAD_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = wp;
        if (len_blk && wp == AddrW'(14)) begin
          ram_wdata = bc[63:32];
        end else if (len_blk && wp == AddrW'(15)) begin
          ram_wdata = bc[31:0];
        end else begin
          ram_wdata = '0;
        end
      end
      S_COMP: begin
        ram_we    = (cnt >= FirstExp);
        ram_waddr = rnd[AddrW-1:0];
        ram_wdata = w_new;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer, chaining words, counters and the digest output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      h0           <= H0_INIT;
      h1           <= H1_INIT;
      h2           <= H2_INIT;
      h3           <= H3_INIT;
      h4           <= H4_INIT;
      bc           <= '0;
      bp           <= '0;
      cnt          <= '0;
      wp           <= '0;
      finishing    <= 1'b0;
      mark_done    <= 1'b0;
      len_blk      <= 1'b0;
      digest_valid <= 1'b0;
    end else begin
      if (digest_valid && digest_ready && (state != S_OUT)) begin
        digest_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take_byte) begin
            acc <= {acc[15:0], byte_data.data_byte};
            bp  <= bp + 6'd1;
            bc  <= bc + 64'd8;
          end
          if (accept && byte_data.last_byte) begin
            finishing <= 1'b1;
          end
          if (take_byte && bp == 6'd63) begin
            cnt   <= '0;
            state <= S_COMP;
          end else if (accept && byte_data.last_byte) begin
            state <= S_PAD_MARK;
          end
        end
        S_PAD_MARK: begin
          mark_done <= 1'b1;
          len_blk   <= (bp < 6'd56);
          wp        <= bp[5:2] + AddrW'(1);
          if (bp[5:2] == AddrW'(15)) begin
            cnt   <= '0;
            state <= S_COMP;
          end else begin
            state <= S_PAD_FILL;
          end
        end
        S_PAD_FILL: begin
          wp <= wp + AddrW'(1);
          if (wp == AddrW'(15)) begin
            cnt   <= '0;
            state <= S_COMP;
          end
        end
        S_COMP: begin
          dl1 <= rd_a;
          dl2 <= dl1;
          if (cnt == 7'd0) begin
            wa <= h0;
            wb <= h1;
            wc <= h2;
            wd <= h3;
            we <= h4;
          end
          if (cnt >= 7'(PreCycles)) begin
            wa  <= t_val;
            wb  <= wa;
            wc  <= {wb[1:0], wb[31:2]};
            wd  <= wc;
            we  <= wd;
            wh0 <= w_new;
            wh1 <= wh0;
            wh2 <= wh1;
          end
          if (cnt == LastCnt) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_FIN: begin
          h0 <= h0 + wa;
          h1 <= h1 + wb;
          h2 <= h2 + wc;
          h3 <= h3 + wd;
          h4 <= h4 + we;
          if (!finishing) begin
            state <= S_IDLE;
          end else if (!mark_done) begin
            state <= S_PAD_MARK;
          end else if (len_blk) begin
            state <= S_OUT;
          end else begin
            len_blk <= 1'b1;
            wp      <= '0;
            state   <= S_PAD_FILL;
          end
        end
        S_OUT: begin
          if (!digest_valid || digest_ready) begin
            digest.digest_high <= {h0, h1};
            digest.digest_mid  <= {h2, h3};
            digest.digest_low  <= h4;
            digest_valid       <= 1'b1;
            h0                 <= H0_INIT;
            h1                 <= H1_INIT;
            h2                 <= H2_INIT;
            h3                 <= H3_INIT;
            h4                 <= H4_INIT;
            bc                 <= '0;
            bp                 <= '0;
            finishing          <= 1'b0;
            mark_done          <= 1'b0;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The round counter never runs past the last round.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_COMP) |-> (cnt <= LastCnt))
    else $error("round counter overran");

  // No byte is taken while a message is being finished.
  assert property (@(posedge clk) disable iff (rst)
    byte_ready |-> !finishing)
    else $error("byte accepted during padding");

  // A length block that has been compressed leads straight to the digest.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && finishing && mark_done && len_blk) |=> (state == S_OUT))
    else $error("length block not followed by digest");

  // Issuing the digest re-arms the counts for the next message.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!digest_valid || digest_ready))
      |=> (digest_valid && bp == 6'd0 && bc == 64'd0 && !finishing))
    else $error("digest issue did not re-arm");

  // Schedule words are only rewritten once the expansion rounds have begun.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_COMP && ram_we) |-> (rnd >= 7'd16))
    else $error("schedule written during a load round");

endmodule
